>>> hdl/tts_pkg.sv
// shared types and constants for the task table scheduler
// used by tts_scan and task_table_scheduler_core; no dependencies
package tts_pkg;

  localparam int NUM_SLOTS = 32;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int CNT_W     = SLOT_W + 1;

  // slot zero is never scheduled, slot one is left alone by the tick sweep
  localparam logic [SLOT_W-1:0] ROOT_SLOT      = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] TICK_SKIP_SLOT = SLOT_W'(1);

  localparam logic [15:0] SCALE_RESET = 16'd1000;
  localparam logic [15:0] STEP_RESET  = 16'd1000;

  // configuration register indexes
  localparam logic REG_SLEEP_SCALE = 1'b0;
  localparam logic REG_TICK_STEP   = 1'b1;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_SCHED  = 3'd1,
    OP_TICK   = 3'd2,
    OP_SLEEP  = 3'd3,
    OP_EXIT   = 3'd4,
    OP_WAIT   = 3'd5,
    OP_WAKE   = 3'd6,
    OP_NOP    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_READY    = 2'd0,
    ST_SLEEPING = 2'd1,
    ST_WAITING  = 2'd2,
    ST_ZOMBIE   = 2'd3
  } task_state_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_NONE = 2'd2
  } status_t;

  // search kinds of the slot scanner
  typedef enum logic [1:0] {
    SCAN_FREE = 2'd0,
    SCAN_LIVE = 2'd1,
    SCAN_USED = 2'd2
  } scan_mode_t;

  typedef struct packed {
    logic              done;
    logic              found;
    logic [SLOT_W-1:0] idx;
  } scan_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CREATE,
    S_TICK,
    S_SLEEP,
    S_NEXT,
    S_PICK,
    S_DONE
  } fsm_t;

  typedef struct packed {
    op_t         opcode;
    logic [4:0]  parent_id;
    logic [4:0]  target_id;
    logic [15:0] sleep_units;
  } tts_item_t;

  typedef struct packed {
    status_t    status;
    logic [4:0] chosen_id;
    logic       switched;
  } tts_result_t;

endpackage

>>> hdl/tts_scan.sv
// slot scanner: walks the task table one slot per cycle from a base slot
// depends on tts_pkg
module tts_scan import tts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  scan_mode_t           mode,
  input  logic [SLOT_W-1:0]    base,
  input  logic [NUM_SLOTS-1:0] used,
  input  logic [NUM_SLOTS-1:0] zombie,
  output scan_res_t            res
);

  logic              busy;
  scan_mode_t        mode_r;
  logic [SLOT_W-1:0] base_r;
  logic [CNT_W-1:0]  k;
  logic [SLOT_W-1:0] idx;
  logic              hit;
  logic              last;

  // slot under test and its match
  always_comb begin
    idx  = base_r + k[SLOT_W-1:0];
    hit  = 1'b0;
    last = 1'b0;
    case (mode_r)
      SCAN_FREE: begin
        hit  = !used[idx];
        last = (k == CNT_W'(NUM_SLOTS - 1));
      end
      SCAN_LIVE: begin
        hit  = used[idx] && !zombie[idx] && (idx != ROOT_SLOT);
        last = (k == CNT_W'(NUM_SLOTS - 1));
      end
      SCAN_USED: begin
        hit  = used[idx];
        last = (k == CNT_W'(NUM_SLOTS));
      end
      default: begin
        hit  = 1'b0;
        last = 1'b1;
      end
    endcase
    res.done  = busy && (hit || last);
    // next-used search falls back to the base slot itself
    res.found = hit || (mode_r == SCAN_USED && last);
    res.idx   = idx;
  end

  // scan counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (res.done) begin
      busy <= 1'b0;
    end
    if (start) begin
      mode_r <= mode;
      base_r <= (mode == SCAN_FREE) ? ROOT_SLOT : base;
      k      <= (mode == SCAN_FREE) ? CNT_W'(0) : CNT_W'(1);
    end else if (busy) begin
      k <= k + CNT_W'(1);
    end
  end

endmodule

>>> hdl/task_table_scheduler_core.sv
// top level of the task table scheduler: table state, sequencer, countdown memory
// depends on tts_pkg and tts_scan
//
// One word is taken at a time; item_ready is high only while the sequencer is
// idle, and a finished result may wait in the output register meanwhile.
// Create, schedule, wait, exit and sleep walk the table through one scanner
// that tests one slot per cycle; create walks to the first free slot, and sleep
// takes a next-used walk then a live walk. Tick sweeps the 32-bit sleep
// countdowns slot by slot, since they live in a memory with one registered
// read and one write port. Wake, the no-op, a wait on slot zero and an exit
// that hands over to its parent need no walk. A result that is not taken
// holds the sequencer in its last state until it is. No clearing pass follows
// reset: a countdown is written when its slot is created and is not used
// before.
module task_table_scheduler_core import tts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  tts_item_t   item,
  output logic        result_valid,
  input  logic        result_ready,
  output tts_result_t result,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [15:0] cfg_data
);

  fsm_t state, state_next;

  logic [15:0]          sleep_scale;
  logic [15:0]          tick_step;
  tts_item_t            item_r;
  logic [SLOT_W-1:0]    cur;
  logic [SLOT_W-1:0]    old_cur;
  status_t              res_status;
  logic                 created;
  logic [SLOT_W-1:0]    claim;
  logic [NUM_SLOTS-1:0] used;
  task_state_t          tstate [NUM_SLOTS];
  logic [SLOT_W-1:0]    parent_of [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] zombie;
  logic [31:0]          sleep_left [NUM_SLOTS];
  logic [31:0]          rdata;
  logic [31:0]          prod;
  logic [CNT_W-1:0]     tk;
  logic                 p_vld;
  logic [SLOT_W-1:0]    p_idx;

  logic                 scan_start;
  scan_mode_t           scan_mode;
  scan_res_t            scan_res;
  logic                 wr_en;
  logic [SLOT_W-1:0]    wr_addr;
  logic [31:0]          wr_data;
  logic [SLOT_W-1:0]    par;
  task_state_t          par_st;
  logic                 wake_parent;
  logic                 tick_hit;
  logic                 expire;
  logic                 out_load;

  assign item_ready = (state == S_IDLE);

  // zombie mask for the scanner
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      zombie[i] = (tstate[i] == ST_ZOMBIE);
    end
  end

  // exit: parent of the current task, seen after it turns zombie
  always_comb begin
    par         = used[cur] ? parent_of[cur] : ROOT_SLOT;
    par_st      = (par == cur) ? ST_ZOMBIE : tstate[par];
    wake_parent = (par != ROOT_SLOT) && used[par] &&
                  (par_st == ST_SLEEPING || par_st == ST_WAITING);
  end

  // tick: sleeper in the slot whose countdown was just read
  assign tick_hit = p_vld && used[p_idx] && (p_idx != TICK_SKIP_SLOT) &&
                    (tstate[p_idx] == ST_SLEEPING);
  assign expire   = (rdata <= {16'd0, tick_step});

  tts_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .start  (scan_start),
    .mode   (scan_mode),
    .base   (cur),
    .used   (used),
    .zombie (zombie),
    .res    (scan_res)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, scanner starts and countdown writes
  always_comb begin
    state_next = state;
    scan_start = 1'b0;
    scan_mode  = SCAN_LIVE;
    wr_en      = 1'b0;
    wr_addr    = cur;
    wr_data    = '0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        if (item_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        case (item_r.opcode)
          OP_CREATE: begin
            scan_start = 1'b1;
            scan_mode  = SCAN_FREE;
            state_next = S_CREATE;
          end
          OP_SCHED: begin
            scan_start = 1'b1;
            state_next = S_PICK;
          end
          OP_TICK: state_next = S_TICK;
          OP_SLEEP: state_next = S_SLEEP;
          OP_EXIT: begin
            if (wake_parent) begin
              state_next = S_DONE;
            end else begin
              scan_start = 1'b1;
              state_next = S_PICK;
            end
          end
          OP_WAIT: begin
            if (item_r.target_id != ROOT_SLOT) begin
              scan_start = 1'b1;
              state_next = S_PICK;
            end else begin
              state_next = S_DONE;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_CREATE: begin
        if (scan_res.done) begin
          state_next = S_DONE;
          if (scan_res.found) begin
            wr_en   = 1'b1;
            wr_addr = scan_res.idx;
          end
        end
      end
      S_TICK: begin
        if (tick_hit) begin
          wr_en   = 1'b1;
          wr_addr = p_idx;
          wr_data = expire ? 32'd0 : rdata - {16'd0, tick_step};
        end
        if (tk == CNT_W'(NUM_SLOTS)) state_next = S_DONE;
      end
      S_SLEEP: begin
        wr_en      = 1'b1;
        wr_data    = prod;
        scan_start = 1'b1;
        scan_mode  = SCAN_USED;
        state_next = S_NEXT;
      end
      S_NEXT: begin
        if (scan_res.done) begin
          if (scan_res.idx != ROOT_SLOT) begin
            scan_start = 1'b1;
            state_next = S_PICK;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_PICK: begin
        if (scan_res.done) state_next = S_DONE;
      end
      S_DONE: begin
        if (!result_valid || result_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // countdown memory
  always_ff @(posedge clk) begin
    if (wr_en) sleep_left[wr_addr] <= wr_data;
    if (state == S_TICK && !tk[SLOT_W]) rdata <= sleep_left[tk[SLOT_W-1:0]];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sleep_scale <= SCALE_RESET;
      tick_step   <= STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SLEEP_SCALE: sleep_scale <= cfg_data;
        REG_TICK_STEP:   tick_step   <= cfg_data;
        default: ;
      endcase
    end
  end

  // table state and item datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      cur  <= ROOT_SLOT;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        tstate[i] <= ST_READY;
      end
    end else begin
      case (state)
        S_EXEC: begin
          case (item_r.opcode)
            OP_SLEEP: tstate[cur] <= ST_SLEEPING;
            OP_EXIT: begin
              tstate[cur] <= ST_ZOMBIE;
              if (wake_parent) begin
                tstate[par] <= ST_READY;
                cur         <= par;
              end
            end
            OP_WAIT: begin
              if (item_r.target_id != ROOT_SLOT) tstate[cur] <= ST_SLEEPING;
            end
            OP_WAKE: tstate[item_r.target_id] <= ST_READY;
            default: ;
          endcase
        end
        S_CREATE: begin
          if (scan_res.done && scan_res.found) begin
            used[scan_res.idx]   <= 1'b1;
            tstate[scan_res.idx] <= ST_READY;
          end
        end
        S_TICK: begin
          if (tick_hit && expire) tstate[p_idx] <= ST_READY;
        end
        S_PICK: begin
          if (scan_res.done && scan_res.found) cur <= scan_res.idx;
        end
        default: ;
      endcase
    end

    // per-item registers
    if (state == S_IDLE && item_valid) begin
      item_r     <= item;
      old_cur    <= cur;
      res_status <= STAT_OK;
      created    <= 1'b0;
    end
    if (state == S_EXEC) begin
      prod <= {16'd0, item_r.sleep_units} * {16'd0, sleep_scale};
      tk   <= '0;
      p_vld <= 1'b0;
    end
    if (state == S_TICK) begin
      tk    <= tk + CNT_W'(1);
      p_vld <= !tk[SLOT_W];
      p_idx <= tk[SLOT_W-1:0];
    end
    if (state == S_CREATE && scan_res.done) begin
      if (scan_res.found) begin
        created               <= 1'b1;
        claim                 <= scan_res.idx;
        parent_of[scan_res.idx] <= item_r.parent_id;
      end else begin
        res_status <= STAT_FULL;
      end
    end
    if (state == S_PICK && scan_res.done && !scan_res.found) res_status <= STAT_NONE;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (out_load) begin
      result.status    <= res_status;
      result.chosen_id <= created ? claim : cur;
      result.switched  <= (cur != old_cur);
    end
  end

  // a task switch only comes with success and never lands on slot zero
  a_switch_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.switched |-> result.status == STAT_OK)
    else $error("switch reported with failing status");

  a_switch_root: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.switched |-> result.chosen_id != ROOT_SLOT)
    else $error("switched to slot zero");

  // the scanner finishes only in a state that waits for it
  a_scan_owner: assert property (@(posedge clk) disable iff (rst)
    scan_res.done |-> (state == S_CREATE || state == S_NEXT || state == S_PICK))
    else $error("scanner finished outside a scan state");

endmodule

>>> dv/tts_result_check.sv
// result checker for the task table scheduler: watches the item, result and register ports,
// keeps its own copy of the task table and compares every result word field by field
// depends on tts_pkg
module tts_result_check import tts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_ready,
  input  tts_item_t   item,
  input  logic        result_valid,
  input  logic        result_ready,
  input  tts_result_t result,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow task table
  logic              slot_live [NUM_SLOTS];
  task_state_t       slot_st   [NUM_SLOTS];
  logic [31:0]       slot_left [NUM_SLOTS];
  logic [SLOT_W-1:0] slot_par  [NUM_SLOTS];
  logic [SLOT_W-1:0] slot_wfor [NUM_SLOTS];
  logic [SLOT_W-1:0] running;
  logic [15:0]       scale_q;
  logic [15:0]       step_q;

  tts_result_t results_due [$];

  // round-robin search after the running task for a live task other than slot zero
  function automatic status_t pick_live();
    int i;
    for (int k = 1; k < NUM_SLOTS; k++) begin
      i = (int'(running) + k) % NUM_SLOTS;
      if (slot_live[i] && slot_st[i] != ST_ZOMBIE && i != int'(ROOT_SLOT)) begin
        running = SLOT_W'(i);
        return STAT_OK;
      end
    end
    return STAT_NONE;
  endfunction

  // first used slot after the running task, the running task itself counted last
  function automatic logic [SLOT_W-1:0] next_used_slot();
    int i;
    for (int k = 1; k <= NUM_SLOTS; k++) begin
      i = (int'(running) + k) % NUM_SLOTS;
      if (slot_live[i]) return SLOT_W'(i);
    end
    return running;
  endfunction

  // apply one operation to the shadow table and return the result word it must give
  function automatic tts_result_t table_step(tts_item_t w);
    tts_result_t       r;
    status_t           stat;
    logic [SLOT_W-1:0] was;
    logic [SLOT_W-1:0] cur;
    logic [SLOT_W-1:0] p;
    logic [63:0]       prod;
    bit                made;
    bit                woke;
    int                slot;
    was  = running;
    cur  = running;
    stat = STAT_OK;
    made = 0;
    woke = 0;
    slot = 0;
    case (w.opcode)
      OP_CREATE: begin
        stat = STAT_FULL;
        for (int i = 0; i < NUM_SLOTS && !made; i++) begin
          if (!slot_live[i]) begin
            slot_live[i] = 1'b1;
            slot_st[i]   = ST_READY;
            slot_left[i] = '0;
            slot_par[i]  = (int'(w.parent_id) < NUM_SLOTS) ? SLOT_W'(w.parent_id) : ROOT_SLOT;
            slot_wfor[i] = '0;
            stat = STAT_OK;
            made = 1;
            slot = i;
          end
        end
      end
      OP_SCHED: stat = pick_live();
      OP_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_live[i] && i != int'(TICK_SKIP_SLOT) && slot_st[i] == ST_SLEEPING) begin
            if (slot_left[i] <= {16'd0, step_q}) begin
              slot_left[i] = '0;
              slot_st[i]   = ST_READY;
            end else begin
              slot_left[i] = slot_left[i] - {16'd0, step_q};
            end
          end
        end
      end
      OP_SLEEP: begin
        prod = 64'(w.sleep_units) * 64'(scale_q);
        if (prod > 64'hFFFF_FFFF) prod = 64'hFFFF_FFFF;
        slot_st[cur]   = ST_SLEEPING;
        slot_left[cur] = prod[31:0];
        if (next_used_slot() != ROOT_SLOT) stat = pick_live();
      end
      OP_EXIT: begin
        p = slot_par[cur];
        slot_st[cur] = ST_ZOMBIE;
        // a blocked parent is woken and runs next
        if (p != ROOT_SLOT && slot_live[p]) begin
          slot_wfor[p] = '0;
          if (slot_st[p] == ST_SLEEPING || slot_st[p] == ST_WAITING) begin
            slot_st[p] = ST_READY;
            running    = p;
            woke       = 1;
          end
        end
        if (!woke) stat = pick_live();
      end
      OP_WAIT: begin
        if (w.target_id != '0) begin
          slot_st[cur]   = ST_SLEEPING;
          slot_wfor[cur] = SLOT_W'(w.target_id);
          stat = pick_live();
        end
      end
      OP_WAKE: begin
        if (int'(w.target_id) < NUM_SLOTS) begin
          slot_wfor[w.target_id] = '0;
          slot_st[w.target_id]   = ST_READY;
        end
      end
      default: ;
    endcase
    r.status    = stat;
    r.chosen_id = made ? 5'(slot) : 5'(running);
    r.switched  = (running != was);
    return r;
  endfunction

  always @(posedge clk) begin
    tts_result_t want;
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_live[i] = 1'b0;
        slot_st[i]   = ST_READY;
        slot_left[i] = '0;
        slot_par[i]  = '0;
        slot_wfor[i] = '0;
      end
      running = '0;
      scale_q = SCALE_RESET;
      step_q  = STEP_RESET;
      results_due.delete();
      fail_count = 0;
      checked    = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        if (cfg_idx == REG_SLEEP_SCALE) scale_q = cfg_data;
        else step_q = cfg_data;
      end
      // compare a delivered word before queuing any new expectation
      if (result_valid && result_ready) begin
        if (results_due.size() == 0) begin
          $error("result word %p arrived with nothing expected", result);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          checked++;
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            fail_count++;
          end
          if (result.chosen_id !== want.chosen_id) begin
            $error("chosen_id: expected %0d, got %0d", want.chosen_id, result.chosen_id);
            fail_count++;
          end
          if (result.switched !== want.switched) begin
            $error("switched: expected %0d, got %0d", want.switched, result.switched);
            fail_count++;
          end
        end
      end
      if (item_valid && item_ready) results_due.push_back(table_step(item));
    end
    pending = results_due.size();
  end

endmodule

>>> dv/tb_task_table_scheduler_core.sv
// testbench top for task_table_scheduler_core: clock, reset, item and register stimulus,
// random stalls on both channels and the final verdict
// depends on tts_pkg and tts_result_check
module tb_task_table_scheduler_core;
  import tts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PHASES = 6;
  localparam int PHASE_WORDS = 190;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  tts_item_t   item = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  tts_result_t result;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = REG_SLEEP_SCALE;
  logic [15:0] cfg_data = '0;

  int fail_count;
  int pending;
  int checked;
  int words_sent = 0;
  int directed_words = 0;
  int tx_calm = 0;
  int rx_hold = 0;
  int rx_calm = 0;

  task_table_scheduler_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data)
  );

  tts_result_check i_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side: random stall after each accepted word, with calm stretches
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      rx_hold = 0;
      rx_calm = 0;
    end else if (result_valid && result_ready) begin
      if (rx_calm > 0) begin
        rx_calm--;
        rx_hold = 0;
      end else begin
        rx_hold = $urandom_range(0, 9);
        if ($urandom_range(0, 15) == 0) rx_calm = $urandom_range(8, 30);
      end
      result_ready <= (rx_hold == 0);
    end else if (rx_hold > 0) begin
      rx_hold--;
      result_ready <= (rx_hold == 0);
    end else begin
      result_ready <= 1'b1;
    end
  end

  function automatic tts_item_t word(op_t op, logic [4:0] par, logic [4:0] tgt,
                                     logic [15:0] units);
    tts_item_t w;
    w.opcode      = op;
    w.parent_id   = par;
    w.target_id   = tgt;
    w.sleep_units = units;
    return w;
  endfunction

  // random operation, weighted so wakes keep revived tasks in play against exits
  function automatic tts_item_t rand_word();
    int pick;
    op_t op;
    logic [15:0] units;
    pick = $urandom_range(0, 99);
    if (pick < 6) op = OP_CREATE;
    else if (pick < 26) op = OP_SCHED;
    else if (pick < 40) op = OP_TICK;
    else if (pick < 55) op = OP_SLEEP;
    else if (pick < 67) op = OP_EXIT;
    else if (pick < 78) op = OP_WAIT;
    else if (pick < 96) op = OP_WAKE;
    else op = OP_NOP;
    case ($urandom_range(0, 9))
      6, 7: units = 16'($urandom_range(0, 65535));
      8: units = 16'hFFFF;
      9: units = 16'd0;
      default: units = 16'($urandom_range(0, 4));
    endcase
    return word(op, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), units);
  endfunction

  // present one word after a random gap; returns at the edge where it is taken
  task automatic send_word(input tts_item_t w);
    int gap;
    if (tx_calm > 0) begin
      tx_calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 15) == 0) tx_calm = $urandom_range(8, 30);
    end
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    words_sent++;
  endtask

  // hold the sender until every expected word has come back
  task automatic drain();
    item_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] scale, input logic [15:0] step);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_SLEEP_SCALE;
    cfg_data <= scale;
    @(posedge clk);
    cfg_idx  <= REG_TICK_STEP;
    cfg_data <= step;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // hand-picked sequence at reset settings: empty table, unused current slot,
  // zero targets, parent hand-off on exit, fruitless search
  task automatic run_directed();
    send_word(word(OP_SCHED,  5'd0,  5'd0,  16'd0));
    send_word(word(OP_SLEEP,  5'd0,  5'd0,  16'd3));
    send_word(word(OP_EXIT,   5'd0,  5'd0,  16'd0));
    send_word(word(OP_WAIT,   5'd0,  5'd0,  16'd0));
    send_word(word(OP_WAKE,   5'd0,  5'd0,  16'd0));
    send_word(word(OP_CREATE, 5'd0,  5'd0,  16'd0));
    send_word(word(OP_CREATE, 5'd31, 5'd31, 16'hFFFF));
    send_word(word(OP_CREATE, 5'd1,  5'd0,  16'd0));
    send_word(word(OP_CREATE, 5'd2,  5'd0,  16'd0));
    send_word(word(OP_SCHED,  5'd0,  5'd0,  16'd0));
    send_word(word(OP_TICK,   5'd0,  5'd0,  16'd0));
    send_word(word(OP_SCHED,  5'd0,  5'd0,  16'd0));
    send_word(word(OP_SLEEP,  5'd0,  5'd0,  16'hFFFF));
    send_word(word(OP_WAIT,   5'd0,  5'd5,  16'd0));
    send_word(word(OP_SCHED,  5'd0,  5'd0,  16'd0));
    send_word(word(OP_EXIT,   5'd0,  5'd0,  16'd0));
    send_word(word(OP_EXIT,   5'd0,  5'd0,  16'd0));
    send_word(word(OP_SLEEP,  5'd0,  5'd0,  16'd1));
    send_word(word(OP_TICK,   5'd0,  5'd0,  16'd0));
    send_word(word(OP_WAKE,   5'd0,  5'd2,  16'd0));
    send_word(word(OP_NOP,    5'd31, 5'd31, 16'hFFFF));
    send_word(word(OP_CREATE, 5'd1,  5'd0,  16'd0));
    send_word(word(OP_SCHED,  5'd0,  5'd0,  16'd0));
    send_word(word(OP_SCHED,  5'd0,  5'd0,  16'd0));
    send_word(word(OP_EXIT,   5'd0,  5'd0,  16'd0));
    directed_words = words_sent;
  endtask

  // main sequence: directed words, then random phases over several register settings
  initial begin
    logic [15:0] scale_tab [NUM_PHASES];
    logic [15:0] step_tab  [NUM_PHASES];
    scale_tab = '{16'd1, 16'hFFFF, 16'd0, 16'd1000, 16'd0, 16'd7};
    step_tab  = '{16'hFFFF, 16'd1, 16'd0, 16'd1000, 16'd0, 16'd3};
    scale_tab[4] = 16'($urandom_range(1, 65535));
    step_tab[4]  = 16'($urandom_range(1, 65535));
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    drain();
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_config(scale_tab[ph], step_tab[ph]);
      repeat (PHASE_WORDS) send_word(rand_word());
      drain();
    end
    repeat (80) @(posedge clk);
    $display("covered %0d directed and %0d random words over %0d register settings",
             directed_words, words_sent - directed_words, NUM_PHASES + 1);
    $display("%0d result words compared, %0d mismatches", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_task_table_scheduler_core OK");
    end else begin
      $display("tb_task_table_scheduler_core NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("tb_task_table_scheduler_core NOT OK");
    $finish;
  end

endmodule
